// ===== sv/aosc_pkg.sv =====
// Shared constants, register codes and types of the audio oscillator.
package aosc_pkg;

  localparam int PHASE_BITS_DEF  = 32;
  localparam int SAMPLE_BITS_DEF = 16;
  localparam int SINE_DEPTH_DEF  = 1024;

  localparam int REG_W     = 32;
  localparam int REG_IDX_W = 2;
  localparam int AMP_W     = 15;
  localparam int WAVE_W    = 2;
  localparam int DIV_QBITS = 30;

  localparam logic [REG_IDX_W-1:0] REG_PHASE_INC   = 2'd0;
  localparam logic [REG_IDX_W-1:0] REG_AMPLITUDE   = 2'd1;
  localparam logic [REG_IDX_W-1:0] REG_WAVEFORM    = 2'd2;
  localparam logic [REG_IDX_W-1:0] REG_START_PHASE = 2'd3;

  localparam logic [WAVE_W-1:0] WAVE_SINE   = 2'd0;
  localparam logic [WAVE_W-1:0] WAVE_SQUARE = 2'd1;
  localparam logic [WAVE_W-1:0] WAVE_SAW    = 2'd2;

  localparam logic [AMP_W-1:0] AMP_RESET = 15'd32767;

  typedef struct packed {
    logic [REG_W-1:0]  phase_inc;
    logic [AMP_W-1:0]  amplitude;
    logic [WAVE_W-1:0] waveform;
    logic [REG_W-1:0]  start_phase;
  } cfg_t;

endpackage

// ===== sv/aosc_front.sv =====
// Front end: configuration registers, tick intake and phase accumulator.
module aosc_front #(
  parameter int PHASE_BITS = aosc_pkg::PHASE_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic                             in_restart,
  input  logic                             cfg_we,
  input  logic [aosc_pkg::REG_IDX_W-1:0]   cfg_index,
  input  logic [aosc_pkg::REG_W-1:0]       cfg_wdata,
  output aosc_pkg::cfg_t                   cfg,
  input  logic                             q_full,
  output logic                             q_push,
  output logic [aosc_pkg::REG_W-1:0]       q_data
);

  aosc_pkg::cfg_t          cfg_r, cfg_nxt;
  logic [PHASE_BITS-1:0]   phase_r, phase_nxt;
  logic [PHASE_BITS-1:0]   inc_acc, start_acc, base, sum;
  logic                    accept;

  if (PHASE_BITS >= 32) begin : g_wide
    localparam int PAD = PHASE_BITS - 32;
    assign inc_acc   = PHASE_BITS'(cfg_r.phase_inc) << PAD;
    assign start_acc = PHASE_BITS'(cfg_r.start_phase) << PAD;
    assign q_data    = 32'(sum >> PAD);
  end else begin : g_narrow
    localparam int CUT = 32 - PHASE_BITS;
    assign inc_acc   = PHASE_BITS'(cfg_r.phase_inc >> CUT);
    assign start_acc = PHASE_BITS'(cfg_r.start_phase >> CUT);
    assign q_data    = 32'(sum) << CUT;
  end

  assign in_stall = q_full;
  assign accept   = in_valid && !q_full;
  assign q_push   = accept;
  assign cfg      = cfg_r;

  always_comb begin
    base      = in_restart ? start_acc : phase_r;
    sum       = base + inc_acc;
    phase_nxt = accept ? sum : phase_r;
  end

  always_comb begin
    cfg_nxt = cfg_r;
    if (cfg_we) begin
      unique case (cfg_index)
        aosc_pkg::REG_PHASE_INC:   cfg_nxt.phase_inc   = cfg_wdata;
        aosc_pkg::REG_AMPLITUDE:   cfg_nxt.amplitude   = cfg_wdata[aosc_pkg::AMP_W-1:0];
        aosc_pkg::REG_WAVEFORM:    cfg_nxt.waveform    = cfg_wdata[aosc_pkg::WAVE_W-1:0];
        aosc_pkg::REG_START_PHASE: cfg_nxt.start_phase = cfg_wdata;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.phase_inc   <= '0;
      cfg_r.amplitude   <= aosc_pkg::AMP_RESET;
      cfg_r.waveform    <= aosc_pkg::WAVE_SINE;
      cfg_r.start_phase <= '0;
      phase_r           <= '0;
    end else begin
      cfg_r   <= cfg_nxt;
      phase_r <= phase_nxt;
    end
  end

endmodule

// ===== sv/aosc_queue.sv =====
// Two-entry queue of phase words between front end and back end.
module aosc_queue (
  input  logic                         clk,
  input  logic                         rst_n,
  input  logic                         push,
  input  logic [aosc_pkg::REG_W-1:0]   push_data,
  input  logic                         pop,
  output logic [aosc_pkg::REG_W-1:0]   pop_data,
  output logic                         full,
  output logic                         empty
);

  logic [aosc_pkg::REG_W-1:0] ent_r [2];
  logic                       wr_ptr_r, wr_ptr_nxt;
  logic                       rd_ptr_r, rd_ptr_nxt;
  logic [1:0]                 cnt_r, cnt_nxt;
  logic                       do_push, do_pop;

  assign full     = (cnt_r == 2'd2);
  assign empty    = (cnt_r == 2'd0);
  assign pop_data = ent_r[rd_ptr_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && !empty;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    cnt_nxt    = cnt_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      ent_r[wr_ptr_r] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      cnt_r    <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

endmodule

// ===== sv/aosc_sine_rom.sv =====
// Quarter-wave sine table with registered read, built at elaboration.
module aosc_sine_rom #(
  parameter int DEPTH = aosc_pkg::SINE_DEPTH_DEF,
  parameter int AW    = $clog2(DEPTH + 1)
) (
  input  logic          clk,
  input  logic [AW-1:0] addr,
  output logic [15:0]   data
);

  localparam logic [63:0] PI_HALF_Q30 = 64'd1686629713;

  function automatic logic [15:0] quarter_sine(input int unsigned k);
    logic [63:0]        x;
    logic [63:0]        x2;
    logic [63:0]        term;
    logic signed [63:0] acc;
    x    = (PI_HALF_Q30 * 64'(k)) / 64'(DEPTH);
    x2   = (x * x) >> 30;
    term = x;
    acc  = $signed(x);
    term = ((term * x2) >> 30) / 64'd6;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd20;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd42;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd72;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd110;
    acc  = acc - $signed(term);
    term = ((term * x2) >> 30) / 64'd156;
    acc  = acc + $signed(term);
    term = ((term * x2) >> 30) / 64'd210;
    acc  = acc - $signed(term);
    if (acc < 0) begin
      acc = 0;
    end
    acc = (acc + 64'sd16384) >>> 15;
    if (acc > 64'sd32768) begin
      acc = 64'sd32768;
    end
    return acc[15:0];
  endfunction

  logic [15:0] rom_tbl [DEPTH + 1];
  logic [15:0] data_r;

  for (genvar k = 0; k <= DEPTH; k++) begin : g_tbl
    assign rom_tbl[k] = quarter_sine(k);
  end

  always_ff @(posedge clk) begin
    data_r <= rom_tbl[addr];
  end

  assign data = data_r;

endmodule

// ===== sv/aosc_div.sv =====
// Restoring divider, one quotient bit per cycle, for fractions below one.
module aosc_div (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              start,
  input  logic [31:0]                       numer,
  input  logic [31:0]                       denom,
  output logic                              done,
  output logic [aosc_pkg::DIV_QBITS-1:0]    quot
);

  localparam int QB = aosc_pkg::DIV_QBITS;
  localparam int CW = $clog2(QB + 1);

  logic [31:0]   rem_r, rem_nxt;
  logic [31:0]   den_r, den_nxt;
  logic [QB-1:0] q_r, q_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          active_r, active_nxt;
  logic          done_r, done_nxt;
  logic [32:0]   rem2;
  logic [32:0]   diff;

  always_comb begin
    rem2       = {rem_r, 1'b0};
    diff       = rem2 - {1'b0, den_r};
    rem_nxt    = rem_r;
    den_nxt    = den_r;
    q_nxt      = q_r;
    cnt_nxt    = cnt_r;
    active_nxt = active_r;
    done_nxt   = 1'b0;
    if (start) begin
      rem_nxt    = numer;
      den_nxt    = denom;
      q_nxt      = '0;
      cnt_nxt    = CW'(QB);
      active_nxt = 1'b1;
    end else if (active_r) begin
      if (!diff[32]) begin
        rem_nxt = diff[31:0];
        q_nxt   = {q_r[QB-2:0], 1'b1};
      end else begin
        rem_nxt = rem2[31:0];
        q_nxt   = {q_r[QB-2:0], 1'b0};
      end
      cnt_nxt = cnt_r - CW'(1);
      if (cnt_r == CW'(1)) begin
        active_nxt = 1'b0;
        done_nxt   = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    rem_r <= rem_nxt;
    den_r <= den_nxt;
    q_r   <= q_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r    <= '0;
      active_r <= 1'b0;
      done_r   <= 1'b0;
    end else begin
      cnt_r    <= cnt_nxt;
      active_r <= active_nxt;
      done_r   <= done_nxt;
    end
  end

  assign done = done_r;
  assign quot = q_r;

endmodule

// ===== sv/aosc_back.sv =====
// Back end: waveform sequencer, scaling, saturation and output register.
module aosc_back #(
  parameter int SAMPLE_BITS      = aosc_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = aosc_pkg::SINE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  aosc_pkg::cfg_t                    cfg,
  input  logic                              q_empty,
  input  logic [aosc_pkg::REG_W-1:0]        q_data,
  output logic                              q_pop,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  output logic [aosc_pkg::REG_W-1:0]        out_phase_now
);

  localparam int AW    = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int PW    = 30 + AW;
  localparam int MAG_W = 18;
  localparam int UP    = (SAMPLE_BITS >= 16) ? SAMPLE_BITS - 16 : 0;
  localparam int DN    = (SAMPLE_BITS < 16) ? 16 - SAMPLE_BITS : 0;
  localparam int SW    = MAG_W + 1;
  localparam int CW    = SW + UP;

  localparam logic signed [33:0]   ONE_Q30 = 34'sd1073741824;
  localparam logic signed [SW-1:0] DN_BIAS = SW'((1 << DN) - 1);
  localparam logic signed [CW-1:0] SAT_HI  = CW'((1 << (SAMPLE_BITS - 1)) - 1);
  localparam logic signed [CW-1:0] SAT_LO  = -SAT_HI - CW'(1);

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_DECODE = 4'd1;
  localparam logic [3:0] S_ROM    = 4'd2;
  localparam logic [3:0] S_SINE   = 4'd3;
  localparam logic [3:0] S_DIV    = 4'd4;
  localparam logic [3:0] S_SQ     = 4'd5;
  localparam logic [3:0] S_BLEP   = 4'd6;
  localparam logic [3:0] S_SAWMUL = 4'd7;
  localparam logic [3:0] S_OUT    = 4'd8;

  logic [3:0]                  state_r, state_nxt;
  logic [31:0]                 w_r, w_nxt;
  logic [31:0]                 v_r, v_nxt;
  logic                        lo_r, lo_nxt;
  logic                        blep_en_r, blep_en_nxt;
  logic                        neg_r, neg_nxt;
  logic [MAG_W-1:0]            mag_r, mag_nxt;
  logic [29:0]                 q_r, q_nxt;
  logic [29:0]                 sq_r, sq_nxt;
  logic [32:0]                 absr_r, absr_nxt;
  logic [AW-1:0]               addr_r, addr_nxt;
  logic                        out_valid_r, out_valid_nxt;
  logic signed [SAMPLE_BITS-1:0] out_sample_r, out_sample_nxt;
  logic [31:0]                 out_phase_r, out_phase_nxt;

  logic [PW-1:0]               idx_prod;
  logic [AW-1:0]               idx;
  logic [31:0]                 v;
  logic [31:0]                 dt;
  logic                        lo, hi;
  logic [31:0]                 numer;
  logic                        div_start, div_done;
  logic [29:0]                 div_quot;
  logic [15:0]                 rom_data;
  logic [31:0]                 sine_prod;
  logic [59:0]                 qq;
  logic signed [33:0]          naive, q2, sqs, blep, r;
  logic [48:0]                 saw_prod;
  logic signed [SW-1:0]        s;
  logic signed [CW-1:0]        scaled;
  logic signed [SAMPLE_BITS-1:0] sat;
  logic                        out_load;

  aosc_sine_rom #(.DEPTH(SINE_TABLE_DEPTH), .AW(AW)) u_rom (
    .clk  (clk),
    .addr (addr_r),
    .data (rom_data)
  );

  aosc_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .numer (numer),
    .denom (dt),
    .done  (div_done),
    .quot  (div_quot)
  );

  always_comb begin
    idx_prod = PW'(w_r[29:0]) * PW'(SINE_TABLE_DEPTH);
    idx      = idx_prod[30 +: AW];
    v        = {~w_r[31], w_r[30:0]};
    dt       = cfg.phase_inc;
    lo       = (dt != '0) && (v < dt);
    hi       = (dt != '0) && ({1'b0, v} > (33'h1_0000_0000 - {1'b0, dt}));
    numer    = lo ? v : 32'(33'h1_0000_0000 - {1'b0, v});

    sine_prod = 32'(rom_data) * 32'(cfg.amplitude) + 32'd16384;
    qq        = 60'(q_r) * 60'(q_r);

    naive = $signed({3'b0, v_r[31:1]}) - ONE_Q30;
    q2    = $signed({3'b0, q_r, 1'b0});
    sqs   = $signed({4'b0, sq_r});
    if (!blep_en_r) begin
      blep = '0;
    end else if (lo_r) begin
      blep = q2 - sqs - ONE_Q30;
    end else begin
      blep = sqs - q2 + ONE_Q30;
    end
    r = naive - blep;

    saw_prod = 49'(absr_r) * 49'(cfg.amplitude) + 49'(1 << 29);

    s      = neg_r ? -$signed({1'b0, mag_r}) : $signed({1'b0, mag_r});
    scaled = CW'((s + (s[SW-1] ? DN_BIAS : SW'(0))) >>> DN) <<< UP;
    if (scaled > SAT_HI) begin
      sat = SAMPLE_BITS'(SAT_HI);
    end else if (scaled < SAT_LO) begin
      sat = SAMPLE_BITS'(SAT_LO);
    end else begin
      sat = SAMPLE_BITS'(scaled);
    end

    out_load = (state_r == S_OUT) && (!out_valid_r || !out_stall);
  end

  always_comb begin
    state_nxt      = state_r;
    w_nxt          = w_r;
    v_nxt          = v_r;
    lo_nxt         = lo_r;
    blep_en_nxt    = blep_en_r;
    neg_nxt        = neg_r;
    mag_nxt        = mag_r;
    q_nxt          = q_r;
    sq_nxt         = sq_r;
    absr_nxt       = absr_r;
    addr_nxt       = addr_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_sample_nxt = out_sample_r;
    out_phase_nxt  = out_phase_r;
    q_pop          = 1'b0;
    div_start      = 1'b0;

    unique case (state_r)
      S_IDLE: begin
        if (!q_empty) begin
          q_pop     = 1'b1;
          w_nxt     = q_data;
          state_nxt = S_DECODE;
        end
      end
      S_DECODE: begin
        unique case (cfg.waveform)
          aosc_pkg::WAVE_SINE: begin
            addr_nxt  = w_r[30] ? AW'(SINE_TABLE_DEPTH) - idx : idx;
            neg_nxt   = w_r[31];
            state_nxt = S_ROM;
          end
          aosc_pkg::WAVE_SQUARE: begin
            mag_nxt   = MAG_W'(cfg.amplitude);
            neg_nxt   = !((w_r != '0) && !w_r[31]);
            state_nxt = S_OUT;
          end
          aosc_pkg::WAVE_SAW: begin
            v_nxt       = v;
            lo_nxt      = lo;
            blep_en_nxt = lo || hi;
            div_start   = lo || hi;
            state_nxt   = (lo || hi) ? S_DIV : S_BLEP;
          end
          default: begin
            mag_nxt   = '0;
            neg_nxt   = 1'b0;
            state_nxt = S_OUT;
          end
        endcase
      end
      S_ROM: begin
        state_nxt = S_SINE;
      end
      S_SINE: begin
        mag_nxt   = MAG_W'(sine_prod >> 15);
        state_nxt = S_OUT;
      end
      S_DIV: begin
        if (div_done) begin
          q_nxt     = div_quot;
          state_nxt = S_SQ;
        end
      end
      S_SQ: begin
        sq_nxt    = qq[59:30];
        state_nxt = S_BLEP;
      end
      S_BLEP: begin
        neg_nxt   = r[33];
        absr_nxt  = r[33] ? 33'(-r) : 33'(r);
        state_nxt = S_SAWMUL;
      end
      S_SAWMUL: begin
        mag_nxt   = MAG_W'(saw_prod >> 30);
        state_nxt = S_OUT;
      end
      S_OUT: begin
        if (out_load) begin
          out_valid_nxt  = 1'b1;
          out_sample_nxt = sat;
          out_phase_nxt  = w_r;
          state_nxt      = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    w_r          <= w_nxt;
    v_r          <= v_nxt;
    lo_r         <= lo_nxt;
    blep_en_r    <= blep_en_nxt;
    neg_r        <= neg_nxt;
    mag_r        <= mag_nxt;
    q_r          <= q_nxt;
    sq_r         <= sq_nxt;
    absr_r       <= absr_nxt;
    addr_r       <= addr_nxt;
    out_sample_r <= out_sample_nxt;
    out_phase_r  <= out_phase_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_sample    = out_sample_r;
  assign out_phase_now = out_phase_r;

endmodule

// ===== sv/audio_oscillator_sine_square_saw.sv =====
// Phase-accumulator oscillator with sine, square and PolyBLEP saw outputs.
//
// Input channel: one transfer per sample tick; in_restart loads the start
// phase before the tick's advance. Result channel: one transfer per tick
// carrying out_sample (signed, saturated) and out_phase_now.
// Configuration: cfg_we writes register cfg_index (0 increment, 1 amplitude,
// 2 waveform, 3 start phase) with cfg_wdata; write only while idle.
// The front end advances the phase in the transfer cycle and queues the
// phase word (two entries); the back end sequencer turns it into a sample.
// Path from input transfer to out_valid: the queue, then for sine decode,
// the registered quarter-wave table read plus one multiply; for square decode
// only; for saw decode and the PolyBLEP and scaling steps, and near its jump
// first the bit-serial divider and the squaring of its quotient. Items are
// processed one at a time: the back end takes a new word only after its last sample.
// Reset clears the phase, the queue and out_valid and loads register reset
// values. While out_stall is high the output register holds; the back end
// finishes one more sample and the queue keeps taking ticks until full,
// then in_stall rises.
module audio_oscillator_sine_square_saw #(
  parameter int PHASE_BITS       = aosc_pkg::PHASE_BITS_DEF,
  parameter int SAMPLE_BITS      = aosc_pkg::SAMPLE_BITS_DEF,
  parameter int SINE_TABLE_DEPTH = aosc_pkg::SINE_DEPTH_DEF
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic                              in_restart,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic signed [SAMPLE_BITS-1:0]     out_sample,
  output logic [31:0]                       out_phase_now,
  input  logic                              cfg_we,
  input  logic [aosc_pkg::REG_IDX_W-1:0]    cfg_index,
  input  logic [aosc_pkg::REG_W-1:0]        cfg_wdata
);

  aosc_pkg::cfg_t             cfg;
  logic                       q_push, q_pop, q_full, q_empty;
  logic [aosc_pkg::REG_W-1:0] q_wdata, q_rdata;

  aosc_front #(.PHASE_BITS(PHASE_BITS)) u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_stall   (in_stall),
    .in_restart (in_restart),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_wdata  (cfg_wdata),
    .cfg        (cfg),
    .q_full     (q_full),
    .q_push     (q_push),
    .q_data     (q_wdata)
  );

  aosc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (q_push),
    .push_data (q_wdata),
    .pop       (q_pop),
    .pop_data  (q_rdata),
    .full      (q_full),
    .empty     (q_empty)
  );

  aosc_back #(
    .SAMPLE_BITS      (SAMPLE_BITS),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_back (
    .clk           (clk),
    .rst_n         (rst_n),
    .cfg           (cfg),
    .q_empty       (q_empty),
    .q_data        (q_rdata),
    .q_pop         (q_pop),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .out_sample    (out_sample),
    .out_phase_now (out_phase_now)
  );

endmodule

// ===== sv/aosc_checker.sv =====
// Port-level checker for the oscillator, bound to the top level.
module aosc_checker #(
  parameter int SAMPLE_BITS = aosc_pkg::SAMPLE_BITS_DEF
) (
  input logic                             clk,
  input logic                             rst_n,
  input logic                             in_valid,
  input logic                             in_stall,
  input logic                             in_restart,
  input logic                             out_valid,
  input logic                             out_stall,
  input logic signed [SAMPLE_BITS-1:0]    out_sample,
  input logic [31:0]                      out_phase_now,
  input logic                             cfg_we
);

  a_out_idle_after_reset: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("out_valid high right after reset");

  a_in_open_after_reset: assert property (@(posedge clk) !rst_n |=> !in_stall)
    else $error("in_stall high right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid && $stable(out_sample) && $stable(out_phase_now))
    else $error("stalled result changed");

  a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_stall |=> in_valid && $stable(in_restart))
    else $error("stalled input changed");

  a_cfg_quiet: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_we |-> !in_valid && !out_valid)
    else $error("register write while a transfer is pending");

endmodule

bind audio_oscillator_sine_square_saw aosc_checker #(.SAMPLE_BITS(SAMPLE_BITS)) u_chk (.*);

// ===== tb/tb.sv =====
// Self-checking testbench for the sine, square and PolyBLEP saw audio oscillator.
module tb;

  localparam int QUIET_LIMIT   = 4000;
  localparam int SETTLE_CYCLES = 48;
  localparam int HOLD_CYCLES   = 200;
  localparam int SINE_DEPTH    = aosc_pkg::SINE_DEPTH_DEF;
  localparam longint unsigned PI_HALF_Q30 = 64'd1686629713;
  localparam longint ONE_Q30 = 64'sd1073741824;
  localparam logic [aosc_pkg::WAVE_W-1:0] WAVE_UNUSED = 2'd3;

  typedef struct {
    logic signed [15:0] sample;
    logic [31:0]        phase;
  } tick_out_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_restart = 1'b0;
  logic out_stall = 1'b0;
  logic cfg_we = 1'b0;
  logic [aosc_pkg::REG_IDX_W-1:0] cfg_index = '0;
  logic [aosc_pkg::REG_W-1:0] cfg_wdata = '0;
  logic in_stall;
  logic out_valid;
  logic signed [15:0] out_sample;
  logic [31:0] out_phase_now;

  logic [aosc_pkg::REG_W-1:0]  inc_reg = '0;
  logic [aosc_pkg::AMP_W-1:0]  amp_reg = aosc_pkg::AMP_RESET;
  logic [aosc_pkg::WAVE_W-1:0] wave_reg = aosc_pkg::WAVE_SINE;
  logic [aosc_pkg::REG_W-1:0]  start_reg = '0;
  logic [31:0]                 phase_acc = '0;

  tick_out_t sample_due[$];
  tick_out_t due_now;
  int errors = 0;
  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int quiet_cycles = 0;
  logic hold_active = 1'b0;
  event hold_begin;

  audio_oscillator_sine_square_saw uut (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .in_restart   (in_restart),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .out_sample   (out_sample),
    .out_phase_now(out_phase_now),
    .cfg_we       (cfg_we),
    .cfg_index    (cfg_index),
    .cfg_wdata    (cfg_wdata)
  );

  initial begin
    forever #6 clk = ~clk;
  end

  function automatic longint quarter_wave(int unsigned k);
    longint unsigned x, x2, term;
    longint sum;
    bit neg;
    neg = 1'b1;
    if (k > SINE_DEPTH) k = SINE_DEPTH;
    x = PI_HALF_Q30 * k / SINE_DEPTH;
    x2 = (x * x) >> 30;
    term = x;
    sum = longint'(x);
    for (int n = 1; n < 15; n += 2) begin
      term = ((term * x2) >> 30) / longint'((n + 1) * (n + 2));
      if (neg) sum -= longint'(term);
      else sum += longint'(term);
      neg = !neg;
    end
    if (sum < 0) sum = 0;
    sum = (sum + 16384) >>> 15;
    if (sum > 32768) sum = 32768;
    return sum;
  endfunction

  function automatic longint sine_level(logic [31:0] w);
    longint unsigned e, mag;
    e = w[30] ? quarter_wave(SINE_DEPTH - w[29:20]) : quarter_wave(w[29:20]);
    mag = (e * amp_reg + 64'd16384) >> 15;
    return w[31] ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic longint saw_level(logic [31:0] w);
    logic [31:0] vw;
    longint unsigned v, dt, t, m, mag;
    longint naive, blep, r;
    vw = w + 32'h8000_0000;
    v = vw;
    dt = inc_reg;
    naive = longint'(v >> 1) - ONE_Q30;
    blep = 0;
    if (dt != 0 && v < dt) begin
      t = (v << 30) / dt;
      blep = 2 * longint'(t) - longint'((t * t) >> 30) - ONE_Q30;
    end else if (dt != 0 && v > 64'h1_0000_0000 - dt) begin
      m = ((64'h1_0000_0000 - v) << 30) / dt;
      blep = longint'((m * m) >> 30) - 2 * longint'(m) + ONE_Q30;
    end
    r = naive - blep;
    mag = (r < 0) ? -r : r;
    mag = (mag * amp_reg + 64'd536870912) >> 30;
    return (r < 0) ? -longint'(mag) : longint'(mag);
  endfunction

  function automatic logic signed [15:0] clamp16(longint q);
    if (q > 32767) return 16'sh7FFF;
    if (q < -32768) return 16'sh8000;
    return q[15:0];
  endfunction

  function automatic tick_out_t oscillator_tick(bit restart);
    tick_out_t res;
    longint q;
    if (restart) phase_acc = start_reg;
    phase_acc = phase_acc + inc_reg;
    case (wave_reg)
      aosc_pkg::WAVE_SINE:   q = sine_level(phase_acc);
      aosc_pkg::WAVE_SQUARE: q = (phase_acc != 0 && !phase_acc[31]) ? longint'(amp_reg)
                                                                    : -longint'(amp_reg);
      aosc_pkg::WAVE_SAW:    q = saw_level(phase_acc);
      default:               q = 0;
    endcase
    res.sample = clamp16(q);
    res.phase = phase_acc;
    return res;
  endfunction

  task automatic send_tick(bit restart);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid <= 1'b1;
    in_restart <= restart;
    do @(posedge clk); while (!(in_valid && !in_stall));
    sample_due.push_back(oscillator_tick(restart));
  endtask

  // drop valid, drain every due sample, then let the back end go quiet
  task automatic settle();
    in_valid <= 1'b0;
    while (sample_due.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(logic [aosc_pkg::REG_IDX_W-1:0] idx,
                           logic [aosc_pkg::REG_W-1:0] data);
    @(posedge clk);
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    case (idx)
      aosc_pkg::REG_PHASE_INC:   inc_reg = data;
      aosc_pkg::REG_AMPLITUDE:   amp_reg = data[aosc_pkg::AMP_W-1:0];
      aosc_pkg::REG_WAVEFORM:    wave_reg = data[aosc_pkg::WAVE_W-1:0];
      aosc_pkg::REG_START_PHASE: start_reg = data;
      default: ;
    endcase
  endtask

  task automatic setup(logic [31:0] inc, logic [aosc_pkg::AMP_W-1:0] amp,
                       logic [aosc_pkg::WAVE_W-1:0] code);
    settle();
    write_reg(aosc_pkg::REG_PHASE_INC, inc);
    write_reg(aosc_pkg::REG_AMPLITUDE, {17'd0, amp});
    write_reg(aosc_pkg::REG_WAVEFORM, {30'd0, code});
  endtask

  task automatic tick_at(logic [31:0] target);
    settle();
    write_reg(aosc_pkg::REG_START_PHASE, target - inc_reg);
    send_tick(1'b1);
  endtask

  task automatic test_reset_state();
    send_tick(1'b0);
    send_tick(1'b1);
  endtask

  task automatic test_sine_quadrants();
    setup(32'd0, aosc_pkg::AMP_RESET, aosc_pkg::WAVE_SINE);
    tick_at(32'h3FFF_FFFF);
    tick_at(32'h4000_0000);
    tick_at(32'h8000_0000);
    tick_at(32'hC000_0000);
    tick_at(32'hFFFF_FFFF);
    setup(32'd0, 15'd1, aosc_pkg::WAVE_SINE);
    tick_at(32'h4000_0000);
  endtask

  task automatic test_square_edges();
    setup(32'd0, aosc_pkg::AMP_RESET, aosc_pkg::WAVE_SQUARE);
    tick_at(32'h0000_0000);
    tick_at(32'h0000_0001);
    tick_at(32'h7FFF_FFFF);
    tick_at(32'h8000_0000);
    setup(32'd0, 15'd0, aosc_pkg::WAVE_SQUARE);
    tick_at(32'h2000_0000);
  endtask

  task automatic test_saw_correction();
    setup(32'd0, aosc_pkg::AMP_RESET, aosc_pkg::WAVE_SAW);
    tick_at(32'h7FFF_FFFF);
    setup(32'h8000_0000, aosc_pkg::AMP_RESET, aosc_pkg::WAVE_SAW);
    tick_at(32'h8000_0000);
    tick_at(32'h7FFF_FFFF);
    setup(32'h1000_0000, aosc_pkg::AMP_RESET, aosc_pkg::WAVE_SAW);
    tick_at(32'h7800_0000);
    tick_at(32'h8000_0001);
    // both correction windows overlap when the increment exceeds one half
    setup(32'hC000_0000, aosc_pkg::AMP_RESET, aosc_pkg::WAVE_SAW);
    tick_at(32'hE000_0000);
  endtask

  task automatic test_unused_waveform();
    setup(32'h0123_4567, aosc_pkg::AMP_RESET, aosc_pkg::WAVE_SINE);
    write_reg(aosc_pkg::REG_WAVEFORM, {30'h2AAA_AAAA, WAVE_UNUSED});
    tick_at(32'h1234_5678);
    send_tick(1'b0);
  endtask

  task automatic configure_random();
    logic [31:0] inc_pick, data;
    logic [aosc_pkg::AMP_W-1:0] amp;
    logic [aosc_pkg::WAVE_W-1:0] code;
    case ($urandom_range(4))
      0:       inc_pick = 32'd0;
      1:       inc_pick = $urandom_range(32'h0010_0000, 1);
      2:       inc_pick = 32'h8000_0000;
      3:       inc_pick = $urandom_range(32'h2000_0000, 32'h0100_0000);
      default: inc_pick = $urandom_range(32'h8000_0000, 0);
    endcase
    case ($urandom_range(3))
      0:       amp = '0;
      1:       amp = aosc_pkg::AMP_RESET;
      default: amp = aosc_pkg::AMP_W'($urandom);
    endcase
    case ($urandom_range(15))
      0:       code = WAVE_UNUSED;
      1, 2, 3: code = aosc_pkg::WAVE_SQUARE;
      4, 5, 6, 7, 8, 9: code = aosc_pkg::WAVE_SAW;
      default: code = aosc_pkg::WAVE_SINE;
    endcase
    write_reg(aosc_pkg::REG_PHASE_INC, inc_pick);
    data = $urandom;
    data[aosc_pkg::AMP_W-1:0] = amp;
    write_reg(aosc_pkg::REG_AMPLITUDE, data);
    data = $urandom;
    data[aosc_pkg::WAVE_W-1:0] = code;
    write_reg(aosc_pkg::REG_WAVEFORM, data);
    write_reg(aosc_pkg::REG_START_PHASE, $urandom);
  endtask

  task automatic test_random_traffic(int send_pct, int recv_pct);
    int n;
    send_idle_pct = send_pct;
    recv_idle_pct = recv_pct;
    repeat (8) begin
      settle();
      configure_random();
      n = $urandom_range(100, 60);
      repeat (n) send_tick($urandom_range(9) == 0);
    end
  endtask

  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    setup(32'h0400_0000, aosc_pkg::AMP_RESET, aosc_pkg::WAVE_SAW);
    -> hold_begin;
    repeat (16) send_tick($urandom_range(1) == 1);
  endtask

  initial begin
    forever begin
      @(hold_begin);
      hold_active <= 1'b1;
      repeat (HOLD_CYCLES) @(posedge clk);
      hold_active <= 1'b0;
    end
  end

  always @(posedge clk) begin
    out_stall <= hold_active || ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) begin
      if (sample_due.size() == 0) begin
        $display("%0t: unexpected transfer: expected none, actual sample %0d phase %h",
                 $time, out_sample, out_phase_now);
        errors++;
      end else begin
        due_now = sample_due.pop_front();
        if (out_sample !== due_now.sample) begin
          $display("%0t: sample mismatch: expected %0d actual %0d",
                   $time, due_now.sample, out_sample);
          errors++;
        end
        if (out_phase_now !== due_now.phase) begin
          $display("%0t: phase_now mismatch: expected %h actual %h",
                   $time, due_now.phase, out_phase_now);
          errors++;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (!rst_n || (in_valid && !in_stall) || (out_valid && !out_stall) || cfg_we) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QUIET_LIMIT) begin
      $display("%0t: watchdog expired with %0d samples due", $time, sample_due.size());
      $display("** audio_oscillator_sine_square_saw: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    test_reset_state();
    test_sine_quadrants();
    test_square_edges();
    test_saw_correction();
    test_unused_waveform();
    test_random_traffic(18, 60);
    test_random_traffic(60, 18);
    test_random_traffic(0, 0);
    test_backpressure();
    settle();
    if (errors == 0) begin
      $display("** audio_oscillator_sine_square_saw: PASSED **");
    end else begin
      $display("** audio_oscillator_sine_square_saw: FAILED **");
    end
    $finish;
  end

endmodule
